// File: rtl/llg_pkg.sv
// ----------------------------------------------------------------------------
// llg_pkg
// Shared types and constants of the LLG torque evaluator.
// ----------------------------------------------------------------------------
package llg_pkg;

    localparam int MAG_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_GYRO = 2'd0;
    localparam logic [1:0] CFG_DAMP = 2'd1;
    localparam logic [1:0] CFG_PREC = 2'd2;

    // One node after classification: m in Q1.15, H, resolved damping and
    // the denominator 2^32 + alpha^2 of the damping scale.
    typedef struct packed {
        logic             first;
        logic [2:0][15:0] mag;
        logic [2:0][31:0] field;
        logic [15:0]      alpha;
        logic [32:0]      den;
    } t_node;

    typedef struct packed {
        logic        start;
        logic [31:0] gamma;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

endpackage

// File: rtl/llg_torque_evaluator.sv
// ----------------------------------------------------------------------------
// llg_torque_evaluator
// Gilbert-form LLG right-hand side per mesh node with a running norm maximum.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one mesh node per word: m, H, optional
// own damping and a first-node flag that clears the running maximum.
// Output channel (o_valid / i_stall): dm/dt components, saturated to 48 bits,
// and the largest norm seen since the last first node.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high (0 gyro ratio, 1 default damping, 2 precession on); write only while
// the block is idle.
// Processing: the back pops a node from the queue, runs 30 products through
// the single shared 51x18 multiplier, each in a multiply and an accumulate
// state, waits on the 32-step divider for the damping scale that runs
// alongside the products, takes the 48-step norm root and loads the result
// word. The back works on one node at a time and pops the next only when idle.
// A two-entry queue lets the input side take nodes while the back works.
// Reset clears the registers (precession on), the queue and the maximum.
// When the receiver stalls, the result word holds and the back waits with
// its next result; the input side stalls once the queue is full.
// ----------------------------------------------------------------------------
module llg_torque_evaluator #(
    parameter int MAG_WIDTH = llg_pkg::MAG_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_first_node,
    input  logic signed [MAG_WIDTH-1:0] i_mag_x,
    input  logic signed [MAG_WIDTH-1:0] i_mag_y,
    input  logic signed [MAG_WIDTH-1:0] i_mag_z,
    input  logic signed [31:0]          i_field_x,
    input  logic signed [31:0]          i_field_y,
    input  logic signed [31:0]          i_field_z,
    input  logic [15:0]                 i_node_damping,
    input  logic                        i_use_node_damping,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [47:0]          o_rate_x,
    output logic signed [47:0]          o_rate_y,
    output logic signed [47:0]          o_rate_z,
    output logic [47:0]                 o_max_rate_norm
);

    logic [31:0] r_gyro_ratio;
    logic [15:0] r_default_damping;
    logic        r_precession_on;

    llg_pkg::t_node    front_node;
    llg_pkg::t_node    queue_node;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    llg_pkg::t_div_req div_req;
    llg_pkg::t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_ratio      <= '0;
            r_default_damping <= '0;
            r_precession_on   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                llg_pkg::CFG_GYRO: r_gyro_ratio      <= i_cfg_data;
                llg_pkg::CFG_DAMP: r_default_damping <= i_cfg_data[15:0];
                llg_pkg::CFG_PREC: r_precession_on   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    llg_front #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_front (
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_first_node       (i_first_node),
        .i_mag_x            (i_mag_x),
        .i_mag_y            (i_mag_y),
        .i_mag_z            (i_mag_z),
        .i_field_x          (i_field_x),
        .i_field_y          (i_field_y),
        .i_field_z          (i_field_z),
        .i_node_damping     (i_node_damping),
        .i_use_node_damping (i_use_node_damping),
        .i_default_damping  (r_default_damping),
        .i_full             (q_full),
        .o_push             (push),
        .o_node             (front_node)
    );

    llg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_node  (front_node),
        .i_pop   (pop),
        .o_node  (queue_node),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    llg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    llg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_node          (queue_node),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .i_gyro_ratio    (r_gyro_ratio),
        .i_precession_on (r_precession_on),
        .o_div_req       (div_req),
        .i_div_rsp       (div_rsp),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_rate_x        (o_rate_x),
        .o_rate_y        (o_rate_y),
        .o_rate_z        (o_rate_z),
        .o_max_rate_norm (o_max_rate_norm)
    );

endmodule

// File: rtl/llg_front.sv
// ----------------------------------------------------------------------------
// llg_front
// Input side: takes a node word, aligns m to Q1.15, picks the damping and
// forms the damping denominator, then pushes the node into the queue.
// ----------------------------------------------------------------------------
module llg_front #(
    parameter int MAG_WIDTH = llg_pkg::MAG_WIDTH_DEF
) (
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_first_node,
    input  logic signed [MAG_WIDTH-1:0] i_mag_x,
    input  logic signed [MAG_WIDTH-1:0] i_mag_y,
    input  logic signed [MAG_WIDTH-1:0] i_mag_z,
    input  logic signed [31:0]          i_field_x,
    input  logic signed [31:0]          i_field_y,
    input  logic signed [31:0]          i_field_z,
    input  logic [15:0]                 i_node_damping,
    input  logic                        i_use_node_damping,
    input  logic [15:0]                 i_default_damping,
    input  logic                        i_full,
    output logic                        o_push,
    output llg_pkg::t_node              o_node
);

    localparam int SHR = (MAG_WIDTH > 16) ? MAG_WIDTH - 16 : 0;
    localparam int SHL = (MAG_WIDTH < 16) ? 16 - MAG_WIDTH : 0;

    function automatic logic signed [15:0] to_q15(input logic signed [MAG_WIDTH-1:0] m);
        logic signed [31:0] e;
        e = 32'(m);
        return 16'((e >>> SHR) <<< SHL);
    endfunction

    logic [15:0] alpha;
    logic [31:0] alpha_sq;

    assign alpha    = i_use_node_damping ? i_node_damping : i_default_damping;
    assign alpha_sq = alpha * alpha;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_node.first    = i_first_node;
        o_node.mag[0]   = to_q15(i_mag_x);
        o_node.mag[1]   = to_q15(i_mag_y);
        o_node.mag[2]   = to_q15(i_mag_z);
        o_node.field[0] = i_field_x;
        o_node.field[1] = i_field_y;
        o_node.field[2] = i_field_z;
        o_node.alpha    = alpha;
        o_node.den      = {1'b1, alpha_sq};
    end

endmodule

// File: rtl/llg_queue.sv
// ----------------------------------------------------------------------------
// llg_queue
// Short queue of classified nodes between the front and the back.
// ----------------------------------------------------------------------------
module llg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  llg_pkg::t_node i_node,
    input  logic           i_pop,
    output llg_pkg::t_node o_node,
    output logic           o_empty,
    output logic           o_full
);

    localparam int DEPTH = llg_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    llg_pkg::t_node r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;

    assign o_node  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/llg_div.sv
// ----------------------------------------------------------------------------
// llg_div
// Restoring divider for the damping scale G = gamma * 2^32 / (2^32 + alpha^2),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module llg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  llg_pkg::t_div_req i_req,
    output llg_pkg::t_div_rsp o_rsp
);

    logic [32:0] r_rem;
    logic [32:0] r_den;
    logic [31:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [33:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem, 1'b0};
    assign fits   = (rem_sh >= {1'b0, r_den});

    assign o_rsp.done = !r_busy;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            // the top 32 dividend bits are gamma itself, below the divisor
            r_rem  <= {1'b0, i_req.gamma};
            r_den  <= i_req.den;
            r_quot <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem  <= fits ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
            r_quot <= {r_quot[30:0], fits};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/llg_back.sv
// ----------------------------------------------------------------------------
// llg_back
// Arithmetic side: runs the cross products, damping, scale and norm through
// one shared 51x18 multiplier, takes the norm root bit by bit and holds the
// result word and the running maximum.
// ----------------------------------------------------------------------------
module llg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  llg_pkg::t_node      i_node,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic [31:0]         i_gyro_ratio,
    input  logic                i_precession_on,
    output llg_pkg::t_div_req   o_div_req,
    input  llg_pkg::t_div_rsp   i_div_rsp,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [47:0]  o_rate_x,
    output logic signed [47:0]  o_rate_y,
    output logic signed [47:0]  o_rate_z,
    output logic [47:0]         o_max_rate_norm
);

    localparam int ACC_W = 100;
    localparam int MA_W  = 51;
    localparam int MB_W  = 18;
    localparam int PR_W  = MA_W + MB_W;

    localparam logic signed [69:0] RATE_HI = (70'sd1 <<< 47) - 70'sd1;
    localparam logic signed [69:0] RATE_LO = -(70'sd1 <<< 47);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_SQRT, S_DONE} t_state;
    typedef enum logic [2:0] {PH_P, PH_D, PH_A, PH_R, PH_N} t_phase;

    t_state             r_state;
    t_phase             r_phase;
    logic [1:0]         r_comp;
    logic [1:0]         r_term;
    logic signed [15:0] r_m    [3];
    logic signed [31:0] r_h    [3];
    logic signed [48:0] r_p    [3];
    logic signed [48:0] r_d    [3];
    logic signed [50:0] r_s    [3];
    logic signed [47:0] r_rate [3];
    logic [15:0]        r_alpha;
    logic               r_first;
    logic signed [PR_W-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [95:0]        r_rad;
    logic [47:0]        r_root;
    logic [51:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [47:0]        r_max;

    // per-component operands
    logic signed [15:0] m1, m2;
    logic signed [31:0] h1, h2;
    logic signed [48:0] p1, p2, p_own;
    logic signed [48:0] d_own;
    logic signed [50:0] s_own;
    logic signed [47:0] rate_own;
    logic [47:0]        abs_own;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic                    neg;
    logic [5:0]              sh_amt;
    logic                    last_term;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] prod_sh;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [69:0]      rate_neg;
    logic signed [47:0]      rate_sat;
    logic [51:0]             rem_s;
    logic [51:0]             trial;
    logic [47:0]             max_base;
    logic [47:0]             n_max;
    logic                    out_free;

    always_comb begin
        case (r_comp)
            2'd0: begin
                m1 = r_m[1]; m2 = r_m[2]; h1 = r_h[1]; h2 = r_h[2];
                p1 = r_p[1]; p2 = r_p[2]; p_own = r_p[0];
                d_own = r_d[0]; s_own = r_s[0]; rate_own = r_rate[0];
            end
            2'd1: begin
                m1 = r_m[2]; m2 = r_m[0]; h1 = r_h[2]; h2 = r_h[0];
                p1 = r_p[2]; p2 = r_p[0]; p_own = r_p[1];
                d_own = r_d[1]; s_own = r_s[1]; rate_own = r_rate[1];
            end
            default: begin
                m1 = r_m[0]; m2 = r_m[1]; h1 = r_h[0]; h2 = r_h[1];
                p1 = r_p[0]; p2 = r_p[1]; p_own = r_p[2];
                d_own = r_d[2]; s_own = r_s[2]; rate_own = r_rate[2];
            end
        endcase
        abs_own = rate_own[47] ? 48'(-rate_own) : 48'(rate_own);
    end

    // operand selection: cross terms are m[i+1]*v[i+2] - m[i+2]*v[i+1]
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        neg       = 1'b0;
        sh_amt    = '0;
        last_term = 1'b0;
        acc_base  = (r_term == 2'd0) ? '0 : r_acc;
        case (r_phase)
            PH_P: begin
                mul_a     = (r_term == 2'd0) ? MA_W'(h2) : MA_W'(h1);
                mul_b     = (r_term == 2'd0) ? MB_W'(m1) : MB_W'(m2);
                neg       = (r_term != 2'd0);
                last_term = (r_term == 2'd1);
            end
            PH_D: begin
                mul_a     = (r_term == 2'd0) ? MA_W'(p2) : MA_W'(p1);
                mul_b     = (r_term == 2'd0) ? MB_W'(m1) : MB_W'(m2);
                neg       = (r_term != 2'd0);
                last_term = (r_term == 2'd1);
            end
            PH_A: begin
                mul_a     = MA_W'(d_own);
                mul_b     = signed'({2'b00, r_alpha});
                last_term = 1'b1;
                acc_base  = i_precession_on ? (ACC_W'(p_own) <<< 16) : '0;
            end
            PH_R: begin
                mul_a     = s_own;
                mul_b     = signed'({2'b00, (r_term == 2'd0) ? i_div_rsp.quot[15:0]
                                                             : i_div_rsp.quot[31:16]});
                sh_amt    = {r_term, 4'b0000};
                last_term = (r_term == 2'd1);
            end
            PH_N: begin
                mul_a     = signed'({3'b000, abs_own});
                mul_b     = signed'({2'b00, abs_own[{r_term, 4'b0000} +: 16]});
                sh_amt    = {r_term, 4'b0000};
                last_term = (r_term == 2'd2);
                // squares of all three components sum in one accumulator
                acc_base  = (r_term == 2'd0 && r_comp == 2'd0) ? '0 : r_acc;
            end
            default: begin
                last_term = 1'b1;
            end
        endcase
        prod_sh = ACC_W'(r_prod) <<< sh_amt;
        n_acc   = neg ? acc_base - prod_sh : acc_base + prod_sh;
    end

    // rate = -floor(G*S / 2^31), saturated to 48 bits
    always_comb begin
        rate_neg = -(70'(signed'(n_acc[ACC_W-1:31])));
        if (rate_neg > RATE_HI) begin
            rate_sat = 48'(RATE_HI);
        end else if (rate_neg < RATE_LO) begin
            rate_sat = 48'(RATE_LO);
        end else begin
            rate_sat = rate_neg[47:0];
        end
    end

    assign rem_s    = {r_rem[49:0], r_rad[95:94]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign max_base = r_first ? '0 : r_max;
    assign n_max    = (r_root > max_base) ? r_root : max_base;
    assign out_free = !o_valid || !i_stall;

    assign o_pop           = (r_state == S_IDLE) && !i_empty;
    assign o_div_req.start = o_pop;
    assign o_div_req.gamma = i_gyro_ratio;
    assign o_div_req.den   = i_node.den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_P;
            r_comp  <= '0;
            r_term  <= '0;
            r_cnt   <= '0;
            r_max   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= signed'(i_node.mag[i]);
                            r_h[i] <= signed'(i_node.field[i]);
                        end
                        r_alpha <= i_node.alpha;
                        r_first <= i_node.first;
                        r_phase <= PH_P;
                        r_comp  <= '0;
                        r_term  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // hold the scale phase until the quotient is in
                    if (r_phase != PH_R || i_div_rsp.done) begin
                        r_prod  <= mul_a * mul_b;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= n_acc;
                    r_state <= S_MUL;
                    if (!last_term) begin
                        r_term <= r_term + 1'b1;
                    end else begin
                        r_term <= '0;
                        case (r_phase)
                            PH_P: r_p[r_comp] <= n_acc[48:0];
                            PH_D: r_d[r_comp] <= n_acc[63:15];
                            PH_A: r_s[r_comp] <= n_acc[66:16];
                            PH_R: r_rate[r_comp] <= rate_sat;
                            default: begin
                            end
                        endcase
                        if (r_comp != 2'd2) begin
                            r_comp <= r_comp + 1'b1;
                        end else begin
                            r_comp <= '0;
                            case (r_phase)
                                PH_P: r_phase <= PH_D;
                                PH_D: r_phase <= PH_A;
                                PH_A: r_phase <= PH_R;
                                PH_R: r_phase <= PH_N;
                                default: begin
                                    r_rad   <= n_acc[95:0];
                                    r_rem   <= '0;
                                    r_root  <= '0;
                                    r_cnt   <= '0;
                                    r_state <= S_SQRT;
                                end
                            endcase
                        end
                    end
                end
                S_SQRT: begin
                    r_rad <= {r_rad[93:0], 2'b00};
                    if (rem_s >= trial) begin
                        r_rem  <= rem_s - trial;
                        r_root <= {r_root[46:0], 1'b1};
                    end else begin
                        r_rem  <= rem_s;
                        r_root <= {r_root[46:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd47) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_rate_x        <= r_rate[0];
                        o_rate_y        <= r_rate[1];
                        o_rate_z        <= r_rate[2];
                        o_max_rate_norm <= n_max;
                        r_max           <= n_max;
                        o_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && !i_empty)
        else $error("node popped outside idle");

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_cnt <= 6'd47))
        else $error("root step count out of range");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && out_free |=> o_valid && (r_state == S_IDLE))
        else $error("finished node not presented");

    a_scale_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) && (r_phase == PH_R) |-> i_div_rsp.done)
        else $error("scale used before quotient done");

endmodule
